>>> src/sosp_pkg.sv
`timescale 1ns / 1ps

package sosp_pkg;

  localparam int unsigned IndexW   = 31;
  localparam int unsigned ValueW   = 32;
  localparam int unsigned CountW   = 11;
  localparam int unsigned CmdW     = 2;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 31;

  localparam logic [ValueW-1:0] UnsetValue = 32'h7FFF_FFFF;

  typedef enum logic [CmdW-1:0] {
    CMD_SET  = 2'd0,
    CMD_SORT = 2'd1,
    CMD_READ = 2'd2,
    CMD_NONE = 2'd3
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    STS_OK      = 2'd0,
    STS_IGNORED = 2'd1,
    STS_RANGE   = 2'd2
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BASE  = 2'd0,
    CFG_COUNT = 2'd1
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FINISH,
    ST_OUTER,
    ST_CUR,
    ST_CURV,
    ST_INNER,
    ST_PREV,
    ST_CMP
  } state_e;

  typedef struct packed {
    logic in_ready;
    logic in_take;
    logic finish;
    logic clr_reset;
    logic clr_step;
    logic outer_rd;
    logic cur_take;
    logic curv_take;
    logic inner_rd;
    logic prev_take;
    logic cmp_step;
    logic place;
    logic out_load;
  } ctrl_t;

  typedef struct packed {
    logic cfg_reinit;
    logic clr_last;
    logic in_fire;
    logic in_is_sort;
    logic i_done;
    logic j_zero;
    logic cur_first;
  } stat_t;

endpackage

>>> src/sosp_if.sv
`timescale 1ns / 1ps

interface sosp_req_if;
  logic                       valid;
  logic                       ready;
  logic [sosp_pkg::CmdW-1:0]   cmd;
  logic [sosp_pkg::IndexW-1:0] item_index;
  logic signed [sosp_pkg::ValueW-1:0] sort_value;
  modport source (output valid, cmd, item_index, sort_value, input ready);
  modport sink   (input valid, cmd, item_index, sort_value, output ready);
endinterface

interface sosp_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [sosp_pkg::StatusW-1:0] status;
  logic [sosp_pkg::IndexW-1:0]  index_out;
  modport source (output valid, status, index_out, input ready);
  modport sink   (input valid, status, index_out, output ready);
endinterface

interface sosp_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [sosp_pkg::CfgIdxW-1:0]  index;
  logic [sosp_pkg::CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> src/sosp_ram.sv
`timescale 1ns / 1ps

module sosp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/sosp_ctrl.sv
`timescale 1ns / 1ps

module sosp_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  sosp_pkg::stat_t sts_i,
  output sosp_pkg::ctrl_t ctrl_o
);
  import sosp_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:  if (sts_i.clr_last) state_d = ST_IDLE;
      ST_IDLE: begin
        if (sts_i.in_fire) state_d = sts_i.in_is_sort ? ST_OUTER : ST_FINISH;
      end
      ST_FINISH: state_d = ST_IDLE;
      ST_OUTER:  state_d = sts_i.i_done ? ST_IDLE : ST_CUR;
      ST_CUR:    state_d = ST_CURV;
      ST_CURV:   state_d = ST_INNER;
      ST_INNER:  state_d = sts_i.j_zero ? ST_OUTER : ST_PREV;
      ST_PREV:   state_d = ST_CMP;
      ST_CMP:    state_d = sts_i.cur_first ? ST_INNER : ST_OUTER;
      default:   state_d = ST_CLEAR;
    endcase
    if (sts_i.cfg_reinit) state_d = ST_CLEAR;
  end

  always_comb begin
    ctrl_o = '0;
    unique case (state_q)
      ST_CLEAR:  ctrl_o.clr_step = 1'b1;
      ST_IDLE: begin
        ctrl_o.in_ready = 1'b1;
        ctrl_o.in_take  = sts_i.in_fire;
      end
      ST_FINISH: begin
        ctrl_o.finish   = 1'b1;
        ctrl_o.out_load = 1'b1;
      end
      ST_OUTER: begin
        ctrl_o.outer_rd = 1'b1;
        ctrl_o.out_load = sts_i.i_done;
      end
      ST_CUR:    ctrl_o.cur_take  = 1'b1;
      ST_CURV:   ctrl_o.curv_take = 1'b1;
      ST_INNER: begin
        ctrl_o.place    = sts_i.j_zero;
        ctrl_o.inner_rd = !sts_i.j_zero;
      end
      ST_PREV:   ctrl_o.prev_take = 1'b1;
      ST_CMP:    ctrl_o.cmp_step  = 1'b1;
      default:   ctrl_o = '0;
    endcase
    if (sts_i.cfg_reinit) begin
      ctrl_o          = '0;
      ctrl_o.clr_reset = 1'b1;
    end
  end

endmodule

>>> src/sosp_dpath.sv
`timescale 1ns / 1ps

module sosp_dpath #(
  parameter int unsigned MAX_ENTRIES = 1024
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  sosp_req_if.sink        req,
  sosp_rsp_if.source      rsp,
  sosp_cfg_if.sink        cfg,
  input  sosp_pkg::ctrl_t ctrl_i,
  output sosp_pkg::stat_t sts_o
);
  import sosp_pkg::*;

  localparam int unsigned OffW = $clog2(MAX_ENTRIES);
  localparam int unsigned CntW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned VramW = ValueW + 1;

  logic [IndexW-1:0] base_q;
  logic [CountW-1:0] count_q;
  logic [CntW-1:0]   live_n;
  logic [OffW-1:0]   clr_q;
  logic [CntW-1:0]   i_q, j_q, j_m1;
  logic [OffW-1:0]   cur_q, prev_q, off_q;
  logic [ValueW-1:0] curv_q, val_q;
  cmd_e              cmd_q;
  logic              inr_q;
  logic [IndexW-1:0] diff;
  logic              in_range;
  logic              out_valid_q;
  logic [StatusW-1:0] status_q;
  logic [IndexW-1:0] index_q;

  logic              idx_we, val_we;
  logic [OffW-1:0]   idx_waddr, idx_wdata, idx_raddr, idx_rdata;
  logic [OffW-1:0]   val_waddr, val_raddr;
  logic [VramW-1:0]  val_wdata, val_rdata;
  logic              cfg_fire, cur_first;
  logic signed [ValueW-1:0] prev_v;

  assign live_n = (32'(count_q) > 32'(MAX_ENTRIES)) ? CntW'(MAX_ENTRIES) : CntW'(count_q);
  assign diff     = req.item_index - base_q;
  assign in_range = (req.item_index >= base_q) && (32'(diff) < 32'(live_n));
  assign j_m1     = j_q - CntW'(1);
  assign prev_v   = $signed(val_rdata[ValueW-1:0]);
  assign cur_first = ($signed(curv_q) < prev_v) ||
                     (($signed(curv_q) == prev_v) && (cur_q < prev_q));

  assign cfg.ready = 1'b1;
  assign cfg_fire  = cfg.valid && cfg.ready;
  assign req.ready = ctrl_i.in_ready && (!out_valid_q || rsp.ready);

  assign sts_o.cfg_reinit = cfg_fire &&
                            (cfg.index == CFG_BASE || cfg.index == CFG_COUNT);
  assign sts_o.clr_last   = (clr_q == OffW'(MAX_ENTRIES - 1));
  assign sts_o.in_fire    = req.valid && req.ready;
  assign sts_o.in_is_sort = (req.cmd == CMD_SORT);
  assign sts_o.i_done     = (i_q >= live_n);
  assign sts_o.j_zero     = (j_q == '0);
  assign sts_o.cur_first  = cur_first;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= '0;
      count_q <= '0;
    end else if (cfg_fire) begin
      if (cfg.index == CFG_BASE)  base_q  <= cfg.data;
      if (cfg.index == CFG_COUNT) count_q <= cfg.data[CountW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (ctrl_i.clr_reset) begin
      clr_q <= '0;
    end else if (ctrl_i.clr_step) begin
      clr_q <= clr_q + OffW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.in_take) begin
      cmd_q <= cmd_e'(req.cmd);
      inr_q <= in_range;
      off_q <= diff[OffW-1:0];
      val_q <= req.sort_value;
      i_q   <= CntW'(1);
    end
    if ((ctrl_i.cmp_step && !cur_first) || ctrl_i.place) i_q <= i_q + CntW'(1);
    if (ctrl_i.cur_take) begin
      cur_q <= idx_rdata;
      j_q   <= i_q;
    end
    if (ctrl_i.cmp_step && cur_first) j_q <= j_m1;
    if (ctrl_i.curv_take) curv_q <= val_rdata[ValueW-1:0];
    if (ctrl_i.prev_take) prev_q <= idx_rdata;
  end

  always_comb begin
    idx_we    = 1'b0;
    idx_waddr = clr_q;
    idx_wdata = clr_q;
    if (ctrl_i.clr_step) idx_we = 1'b1;
    if (ctrl_i.cmp_step) begin
      idx_we    = 1'b1;
      idx_waddr = j_q[OffW-1:0];
      idx_wdata = cur_first ? prev_q : cur_q;
    end
    if (ctrl_i.place) begin
      idx_we    = 1'b1;
      idx_waddr = j_q[OffW-1:0];
      idx_wdata = cur_q;
    end
    idx_raddr = diff[OffW-1:0];
    if (ctrl_i.outer_rd) idx_raddr = i_q[OffW-1:0];
    if (ctrl_i.inner_rd) idx_raddr = j_m1[OffW-1:0];

    val_we    = 1'b0;
    val_waddr = clr_q;
    val_wdata = {1'b0, UnsetValue};
    if (ctrl_i.clr_step) val_we = 1'b1;
    if (ctrl_i.finish && cmd_q == CMD_SET && inr_q && !val_rdata[ValueW]) begin
      val_we    = 1'b1;
      val_waddr = off_q;
      val_wdata = {1'b1, val_q};
    end
    val_raddr = diff[OffW-1:0];
    if (ctrl_i.cur_take || ctrl_i.prev_take) val_raddr = idx_rdata;
  end

  sosp_ram #(.WIDTH(OffW), .DEPTH(MAX_ENTRIES)) u_idx_ram (
    .clk_i   (clk_i),
    .we_i    (idx_we),
    .waddr_i (idx_waddr),
    .wdata_i (idx_wdata),
    .raddr_i (idx_raddr),
    .rdata_o (idx_rdata)
  );

  sosp_ram #(.WIDTH(VramW), .DEPTH(MAX_ENTRIES)) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (val_waddr),
    .wdata_i (val_wdata),
    .raddr_i (val_raddr),
    .rdata_o (val_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (rsp.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.out_load) begin
      status_q <= STS_OK;
      index_q  <= '0;
      unique case (cmd_q)
        CMD_SET: begin
          if (!inr_q) status_q <= STS_RANGE;
          else if (val_rdata[ValueW]) status_q <= STS_IGNORED;
        end
        CMD_READ: begin
          if (!inr_q) status_q <= STS_RANGE;
          else index_q <= base_q + IndexW'(idx_rdata);
        end
        default: status_q <= STS_OK;
      endcase
    end
  end

  assign rsp.valid     = out_valid_q;
  assign rsp.status    = status_q;
  assign rsp.index_out = index_q;

endmodule

>>> src/set_once_key_sort_permutation.sv
`timescale 1ns / 1ps
// channel  dir  payload                          request accepted when
// req      in   cmd, item_index, sort_value      req.valid && req.ready
// rsp      out  status, index_out                rsp.valid && rsp.ready
// cfg      in   index, data                      cfg.valid && cfg.ready
//
// Set and read do one read of a table memory, then register the result.
// Sort is an insertion sort over the index memory: OUTER, CUR and CURV fetch
// each new entry and its value; INNER, PREV and CMP make each compare step,
// and INNER places an entry that reaches the front. Each compare step waits
// on two dependent memory reads. Reset and every write of base or count clear
// all MAX_ENTRIES entries, holding off req. Result waits in an output register.

module set_once_key_sort_permutation #(
  parameter int unsigned MAX_ENTRIES = 1024
) (
  input logic        clk_i,
  input logic        rst_ni,
  sosp_req_if.sink   req,
  sosp_rsp_if.source rsp,
  sosp_cfg_if.sink   cfg
);
  import sosp_pkg::*;

  ctrl_t ctrl;
  stat_t sts;

  sosp_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .ctrl_o (ctrl)
  );

  sosp_dpath #(.MAX_ENTRIES(MAX_ENTRIES)) u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req),
    .rsp    (rsp),
    .cfg    (cfg),
    .ctrl_i (ctrl),
    .sts_o  (sts)
  );

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import sosp_pkg::*;

  localparam int unsigned Entries = 1024;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always #5 clk_i = ~clk_i;

  sosp_req_if req ();
  sosp_rsp_if rsp ();
  sosp_cfg_if cfg ();

  set_once_key_sort_permutation #(.MAX_ENTRIES(Entries)) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req   (req),
    .rsp   (rsp),
    .cfg   (cfg)
  );

  typedef struct packed {
    status_e               status;
    logic [IndexW-1:0]     index_out;
  } answer_t;

  typedef struct {
    cmd_e              cmd;
    logic [IndexW-1:0] item_index;
    logic [ValueW-1:0] sort_value;
    logic              typed;
    answer_t           answer;
  } row_t;

  logic [IndexW-1:0] perm_base;
  logic [CountW-1:0] perm_count;
  logic [9:0]        order_tab[Entries];
  logic [ValueW-1:0] value_tab[Entries];
  logic              taken_tab[Entries];

  answer_t answer_q[$];
  int      errors = 0;
  int      in_idle_pct = 21;
  int      out_idle_pct = 21;
  int      hold_cycles = 0;
  logic    draining = 1'b0;

  function automatic int unsigned span();
    return (perm_count > Entries) ? Entries : perm_count;
  endfunction

  function automatic void clear_tables();
    for (int i = 0; i < Entries; i++) begin
      order_tab[i] = i[9:0];
      value_tab[i] = UnsetValue;
      taken_tab[i] = 1'b0;
    end
  endfunction

  function automatic logic goes_first(logic [9:0] a, logic [9:0] b);
    logic signed [ValueW-1:0] va;
    logic signed [ValueW-1:0] vb;
    va = value_tab[a];
    vb = value_tab[b];
    if (va != vb) return va < vb;
    return a < b;
  endfunction

  function automatic longint offset_in_range(logic [IndexW-1:0] item);
    if (item < perm_base) return -1;
    if ((item - perm_base) >= span()) return -1;
    return longint'(item - perm_base);
  endfunction

  function automatic answer_t permute_step(cmd_e cmd, logic [IndexW-1:0] item,
                                           logic [ValueW-1:0] val);
    answer_t a;
    longint  off;
    int      j;
    logic [9:0] cur;
    a.status = STS_OK;
    a.index_out = '0;
    case (cmd)
      CMD_SET: begin
        off = offset_in_range(item);
        if (off < 0) a.status = STS_RANGE;
        else if (taken_tab[off]) a.status = STS_IGNORED;
        else begin
          taken_tab[off] = 1'b1;
          value_tab[off] = val;
        end
      end
      CMD_SORT: begin
        for (int i = 1; i < span(); i++) begin
          cur = order_tab[i];
          j = i;
          while (j > 0 && goes_first(cur, order_tab[j-1])) begin
            order_tab[j] = order_tab[j-1];
            j--;
          end
          order_tab[j] = cur;
        end
      end
      CMD_READ: begin
        off = offset_in_range(item);
        if (off < 0) a.status = STS_RANGE;
        else a.index_out = perm_base + IndexW'(order_tab[off]);
      end
      default: ;
    endcase
    return a;
  endfunction

  task automatic write_reg(cfg_reg_e idx, logic [CfgDataW-1:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= data;
    do @(posedge clk_i); while (!cfg.ready);
    cfg.valid <= 1'b0;
    if (idx == CFG_BASE) perm_base = data;
    else perm_count = data[CountW-1:0];
    clear_tables();
    @(posedge clk_i);
  endtask

  task automatic send(cmd_e cmd, logic [IndexW-1:0] item, logic [ValueW-1:0] val,
                      logic typed, answer_t typed_ans);
    answer_t a;
    while ($urandom_range(99) < in_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk_i);
    end
    req.valid      <= 1'b1;
    req.cmd        <= cmd;
    req.item_index <= item;
    req.sort_value <= val;
    do @(posedge clk_i); while (!req.ready);
    a = permute_step(cmd, item, val);
    if (typed && a != typed_ans) begin
      $display("%0t table row predicted %p, typed %p", $time, a, typed_ans);
      errors++;
    end
    answer_q.push_back(typed ? typed_ans : a);
  endtask

  task automatic settle();
    req.valid <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [IndexW-1:0] pick_index();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 85) return IndexW'(perm_base + $urandom_range(span() == 0 ? 0 : span() - 1));
    if (r < 92) return IndexW'(perm_base + span() + $urandom_range(3));
    if (r < 96) return IndexW'(perm_base - 1 - $urandom_range(3));
    return IndexW'($urandom());
  endfunction

  function automatic logic [ValueW-1:0] pick_value();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return UnsetValue;
      2: return $urandom_range(7);
      default: return $urandom();
    endcase
  endfunction

  function automatic cmd_e pick_cmd();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return CMD_SET;
    if (r < 60) return CMD_SORT;
    if (r < 97) return CMD_READ;
    return CMD_NONE;
  endfunction

  always @(posedge clk_i) begin
    answer_t got;
    answer_t want;
    if (rst_ni && rsp.valid && rsp.ready) begin
      got.status = status_e'(rsp.status);
      got.index_out = rsp.index_out;
      if (answer_q.size() == 0) begin
        $display("%0t unexpected response: expected none, actual %p", $time, got);
        errors++;
      end else begin
        want = answer_q.pop_front();
        if (got.status != want.status) begin
          $display("%0t status: expected %0d, actual %0d", $time, want.status, got.status);
          errors++;
        end
        if (got.index_out != want.index_out) begin
          $display("%0t index_out: expected %0h, actual %0h", $time,
                   want.index_out, got.index_out);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) rsp.ready <= 1'b0;
    else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      rsp.ready <= 1'b0;
    end else rsp.ready <= draining || ($urandom_range(99) >= out_idle_pct);
  end

  row_t rows[$];

  function automatic void add_row(cmd_e c, logic [IndexW-1:0] i, logic [ValueW-1:0] v,
                                  logic t = 1'b0, status_e s = STS_OK,
                                  logic [IndexW-1:0] o = '0);
    row_t r;
    r.cmd = c; r.item_index = i; r.sort_value = v; r.typed = t;
    r.answer.status = s; r.answer.index_out = o;
    rows.push_back(r);
  endfunction

  initial begin
    answer_t none;
    int unsigned sent;
    none = '0;
    req.valid = 1'b0; req.cmd = CMD_SET; req.item_index = '0; req.sort_value = '0;
    cfg.valid = 1'b0; cfg.index = CFG_BASE; cfg.data = '0;
    perm_base = '0; perm_count = '0;
    clear_tables();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_row(CMD_READ, 31'd0, 32'd0, 1'b1, STS_RANGE);
    add_row(CMD_SET, 31'd0, 32'd5, 1'b1, STS_RANGE);
    foreach (rows[k]) send(rows[k].cmd, rows[k].item_index, rows[k].sort_value,
                           rows[k].typed, rows[k].answer);
    settle();
    rows.delete();

    write_reg(CFG_BASE, 31'h7FFF_FFFC);
    write_reg(CFG_COUNT, 31'd8);
    add_row(CMD_READ, 31'h7FFF_FFFC, 32'd0, 1'b1, STS_OK, 31'h7FFF_FFFC);
    add_row(CMD_READ, 31'h7FFF_FFFB, 32'd0, 1'b1, STS_RANGE);
    add_row(CMD_SET, 31'h7FFF_FFFF, 32'h8000_0000, 1'b1, STS_OK);
    add_row(CMD_SET, 31'h7FFF_FFFF, 32'd1, 1'b1, STS_IGNORED);
    add_row(CMD_SET, 31'h7FFF_FFFC, UnsetValue, 1'b1, STS_OK);
    add_row(CMD_SET, 31'h7FFF_FFFC, 32'd0, 1'b1, STS_IGNORED);
    add_row(CMD_SET, 31'h7FFF_FFFD, 32'hFFFF_FFFF);
    add_row(CMD_SET, 31'h7FFF_FFFE, 32'hFFFF_FFFF);
    add_row(CMD_NONE, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, STS_OK);
    add_row(CMD_SORT, 31'd0, 32'd0, 1'b1, STS_OK);
    for (int p = 0; p < 8; p++) add_row(CMD_READ, IndexW'(31'h7FFF_FFFC + p), 32'd0);
    foreach (rows[k]) send(rows[k].cmd, rows[k].item_index, rows[k].sort_value,
                           rows[k].typed, rows[k].answer);
    settle();

    sent = 0;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin write_reg(CFG_BASE, 31'd0); write_reg(CFG_COUNT, 31'd16); end
        1: begin write_reg(CFG_BASE, 31'd1000); write_reg(CFG_COUNT, 31'd5); end
        2: begin write_reg(CFG_BASE, 31'd2147482623); write_reg(CFG_COUNT, 31'd1024); end
        3: begin write_reg(CFG_COUNT, 31'h7FF); write_reg(CFG_BASE, 31'd77); end
        4: begin write_reg(CFG_BASE, CfgDataW'($urandom())); write_reg(CFG_COUNT, 31'd1); end
        default: begin write_reg(CFG_BASE, 31'd3); write_reg(CFG_COUNT, 31'd0); end
      endcase
      in_idle_pct = (phase == 1) ? 0 : 21;
      out_idle_pct = (phase == 1) ? 0 : 21;
      for (int n = 0; n < 260; n++) begin
        cmd_e c;
        c = pick_cmd();
        if (c == CMD_SORT && span() > 64 && $urandom_range(9) != 0) c = CMD_READ;
        if (phase == 0 && n == 20) hold_cycles <= 300;
        send(c, pick_index(), pick_value(), 1'b0, none);
        sent++;
      end
      settle();
    end

    draining <= 1'b1;
    fork
      while (answer_q.size() != 0) @(posedge clk_i);
    join
    repeat (50) @(posedge clk_i);
    if (errors == 0 && answer_q.size() == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #2s;
    $display("Some tests failed");
    $finish;
  end

endmodule

>>> filelist.f
src/sosp_pkg.sv
src/sosp_if.sv
src/sosp_ram.sv
src/sosp_ctrl.sv
src/sosp_dpath.sv
src/set_once_key_sort_permutation.sv
bench/testbench.sv
